// ===== design/window_photometric_consistency_macros.svh =====
// Assertion macros for the photometric consistency block.
`ifndef WINDOW_PHOTOMETRIC_CONSISTENCY_MACROS_SVH
`define WINDOW_PHOTOMETRIC_CONSISTENCY_MACROS_SVH
// Implication checked at every edge outside reset.
`define WPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define WPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== design/wpc_pkg.sv =====
// Package: types, constants and codes of the photometric consistency block.
package wpc_pkg;
	localparam int WindowMaxDefault = 64;
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_CHECK = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] REG_WLEN   = 2'd0;
	localparam logic [1:0] REG_VLIM   = 2'd1;
	localparam logic [1:0] REG_SLIM   = 2'd2;
	localparam logic [1:0] REG_RFLOOR = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        luma_sample;
		logic [15:0]        exposure_sample;
		logic [14:0]        lab_lightness;
		logic signed [15:0] lab_green_red;
		logic signed [15:0] lab_blue_yellow;
	} in_item_t;

	typedef struct packed {
		logic [31:0] luma_variance;
		logic [16:0] color_spread;
		logic [16:0] exposure_ratio;
		logic        limits_met;
		logic [16:0] fill_confidence;
	} out_item_t;

	// controller -> datapath commands
	typedef struct packed {
		logic push;
		logic clear;
		logic start_check;   // latch n, first; clear accumulators
		logic rd_issue;      // issue a ring read at the walk index
		logic acc1;          // accumulate pass-1 sums from registered read
		logic acc2_start;    // start distance/root work for registered read
		logic fin_start;     // start the final division stage
		logic load_out;      // capture result into output register
	} cmd_t;

	typedef struct packed {
		logic few;           // fewer than two samples held
		logic walk_last;     // walk index at last element
		logic unit_busy;     // iterative unit still working
	} sts_t;
endpackage

// ===== design/wpc_datapath.sv =====
// Datapath: sample rings, accumulators, shared square-root and divide unit.
module wpc_datapath #(
	parameter int WINDOW_MAX = wpc_pkg::WindowMaxDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wpc_pkg::cmd_t      cmd,
	output wpc_pkg::sts_t      sts,
	input  wpc_pkg::in_item_t  in_item,
	input  logic [6:0]         window_length,
	input  logic [31:0]        luma_variance_limit,
	input  logic [16:0]        color_spread_limit,
	input  logic [16:0]        exposure_ratio_floor,
	output wpc_pkg::out_item_t result
);
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int SW = 16 + CW + 2;     // signed lab sum width
	localparam int DW = 2 * SW + 2;      // squared distance width
	localparam int RW = DW / 2 + 1;      // root width
	localparam int AccW = RW + CW;
	localparam int NumW = 32 + 2 * CW + 1;
	localparam int DivW = NumW;
	localparam logic [AW:0] WMAX = (AW + 1)'(WINDOW_MAX);

	// clamp window length to 1..WINDOW_MAX
	logic [CW-1:0] wlen;
	always_comb begin
		if (window_length == 7'd0) wlen = CW'(1);
		else if (32'(window_length) > 32'(WINDOW_MAX)) wlen = CW'(WINDOW_MAX);
		else wlen = CW'(window_length);
	end

	logic [AW-1:0] wslot_q;
	logic [CW-1:0] held_q;
	logic [AW-1:0] first_q, idx_q;
	logic [CW-1:0] n_q, cnt_q;

	// held count as seen after a shortening register write
	logic [CW-1:0] held_c;
	assign held_c = (held_q > wlen) ? wlen : held_q;

	logic [15:0] luma_mem [WINDOW_MAX];
	logic [15:0] expo_mem [WINDOW_MAX];
	logic [46:0] lab_mem  [WINDOW_MAX];
	logic [15:0] luma_rd_q, expo_rd_q;
	logic [46:0] lab_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			luma_mem[wslot_q] <= in_item.luma_sample;
			expo_mem[wslot_q] <= in_item.exposure_sample;
			lab_mem[wslot_q]  <= {in_item.lab_blue_yellow, in_item.lab_green_red,
				in_item.lab_lightness};
		end
		luma_rd_q <= luma_mem[idx_q];
		expo_rd_q <= expo_mem[idx_q];
		lab_rd_q  <= lab_mem[idx_q];
	end

	logic [AW:0] first_c;
	always_comb begin
		first_c = {1'b0, wslot_q} + WMAX - (AW + 1)'(held_c);
		if (first_c >= WMAX) first_c = first_c - WMAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			held_q  <= '0;
		end else if (cmd.clear) begin
			wslot_q <= '0;
			held_q  <= '0;
		end else if (cmd.push) begin
			wslot_q <= (32'(wslot_q) == WINDOW_MAX - 1) ? '0 : wslot_q + 1'b1;
			if (held_c < wlen) held_q <= held_c + 1'b1;
			else held_q <= held_c;
		end else if (held_q > wlen) begin
			held_q <= wlen;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_check) begin
			n_q     <= held_c;
			first_q <= AW'(first_c);
			idx_q   <= AW'(first_c);
			cnt_q   <= '0;
		end else if (cmd.rd_issue) begin
			idx_q <= (32'(idx_q) == WINDOW_MAX - 1) ? '0 : idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.acc1 && sts.walk_last) begin
			idx_q <= first_q;
			cnt_q <= '0;
		end
	end

	// pass 1 sums
	logic [16+CW-1:0]   s1_q;
	logic [32+CW-1:0]   s2_q;
	logic [15:0]        emin_q, emax_q;
	logic signed [SW-1:0] ls_q [3];
	logic [AccW-1:0]    acc_q;

	logic signed [SW-1:0] part [3];
	assign part[0] = SW'($signed({1'b0, lab_rd_q[14:0]}));
	assign part[1] = SW'($signed(lab_rd_q[30:15]));
	assign part[2] = SW'($signed(lab_rd_q[46:31]));

	always_ff @(posedge clk) begin
		if (cmd.start_check) begin
			s1_q   <= '0;
			s2_q   <= '0;
			emin_q <= 16'hFFFF;
			emax_q <= '0;
			for (int k = 0; k < 3; k++) ls_q[k] <= '0;
		end else if (cmd.acc1) begin
			s1_q <= s1_q + (16 + CW)'(luma_rd_q);
			s2_q <= s2_q + (32 + CW)'(luma_rd_q * luma_rd_q);
			if (expo_rd_q < emin_q) emin_q <= expo_rd_q;
			if (expo_rd_q > emax_q) emax_q <= expo_rd_q;
			for (int k = 0; k < 3; k++) ls_q[k] <= ls_q[k] + part[k];
		end
	end

	// pass 2: per element distance, one component a cycle, then root
	logic signed [SW+CW-1:0] dev_c;
	logic [1:0]        comp_q;
	logic [SW+CW-1:0]  mag_s1;
	logic [DW-1:0]     d2_q;
	logic [15:0]       part_hold_q [3];
	typedef enum logic [5:0] {
		U_IDLE = 6'b000001, U_DEV = 6'b000010, U_SQ = 6'b000100,
		U_ROOT = 6'b001000, U_DIV = 6'b010000, U_DONE = 6'b100000
	} ustate_t;
	ustate_t ust_q;
	logic [DW-1:0] rx_q, rr_q, rbit_q;
	logic [6:0]    dsel_q;   // set once the first division is loaded; gates storing a quotient
	logic [DivW-1:0] num_q, den_q, quo_q, rem_q;
	logic [$clog2(DivW+1)-1:0] dcnt_q;
	logic [31:0] var_q;
	logic [16:0] ratio_q, spread_q, conf_q;
	logic [1:0]  dstep_q;
	logic [NumW-1:0] mul_s1;

	assign dev_c = $signed({1'b0, n_q}) * $signed(SW'($signed(
		(comp_q == 2'd0) ? {1'b0, part_hold_q[0][14:0]} : part_hold_q[comp_q]))) -
		(SW + CW)'(ls_q[comp_q]);

	logic [DW:0] rtry;
	assign rtry = {1'b0, rr_q} + {1'b0, rbit_q};

	logic [DivW:0] rem_sh;
	assign rem_sh = {rem_q, num_q[DivW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q <= U_IDLE;
		end else begin
			case (ust_q)
				U_IDLE: begin
					if (cmd.acc2_start) ust_q <= U_DEV;
					else if (cmd.fin_start) ust_q <= U_DIV;
				end
				U_DEV:  if (comp_q == 2'd2) ust_q <= U_SQ;
				U_SQ:   ust_q <= U_ROOT;
				U_ROOT: if (rbit_q == '0) ust_q <= U_IDLE;
				U_DIV: begin
					if (dcnt_q == '0 && dstep_q == 2'd3) ust_q <= U_DONE;
				end
				U_DONE: ust_q <= U_IDLE;
				default: ust_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_check) acc_q <= '0;
		case (ust_q)
			U_IDLE: begin
				if (cmd.acc2_start) begin
					part_hold_q[0] <= {1'b0, lab_rd_q[14:0]};
					part_hold_q[1] <= lab_rd_q[30:15];
					part_hold_q[2] <= lab_rd_q[46:31];
					comp_q <= '0;
					d2_q   <= '0;
				end
				if (cmd.fin_start) begin
					dstep_q <= '0;
					dsel_q  <= '0;
					mul_s1  <= NumW'(n_q) * NumW'(s2_q) - NumW'(s1_q) * NumW'(s1_q);
					den_q   <= DivW'(n_q) * DivW'(n_q);
					dcnt_q  <= '0;
				end
			end
			U_DEV: begin
				mag_s1 <= dev_c[SW+CW-1] ? (SW + CW)'(-dev_c) : (SW + CW)'(dev_c);
				comp_q <= comp_q + 1'b1;
				if (comp_q != 2'd0) d2_q <= d2_q + DW'(mag_s1 * mag_s1);
			end
			U_SQ: begin
				rx_q   <= d2_q + DW'(mag_s1 * mag_s1);
				rr_q   <= '0;
				rbit_q <= DW'(1) << (DW - 2);
			end
			U_ROOT: begin
				if (rbit_q != '0) begin
					if ({1'b0, rx_q} >= rtry) begin
						rx_q <= rx_q - DW'(rtry);
						rr_q <= (rr_q >> 1) + rbit_q;
					end else begin
						rr_q <= rr_q >> 1;
					end
					rbit_q <= rbit_q >> 2;
				end else begin
					acc_q <= acc_q + AccW'(rr_q);
				end
			end
			U_DIV: begin
				if (dcnt_q == '0) begin
					// load next division operands, or store the last quotient
					if (dsel_q != '0) begin
						case (dstep_q)
							2'd1: var_q <= (quo_q > DivW'(32'hFFFFFFFF)) ? 32'hFFFFFFFF
								: quo_q[31:0];
							2'd2: ratio_q <= (emax_q == '0) ? 17'd65536 : quo_q[16:0];
							2'd3: spread_q <= (quo_q > DivW'(17'h1FFFF)) ? 17'h1FFFF
								: quo_q[16:0];
							default: ;
						endcase
					end
					case (dstep_q)
						2'd0: num_q <= mul_s1;
						2'd1: begin
							num_q <= DivW'({emin_q, 16'h0000});
							den_q <= (emax_q == '0) ? DivW'(1) : DivW'(emax_q);
						end
						2'd2: begin
							num_q <= DivW'(acc_q);
							den_q <= DivW'(n_q) * DivW'(n_q);
						end
						default: ;
					endcase
					rem_q   <= '0;
					quo_q   <= '0;
					dsel_q  <= 7'd1;
					if (dstep_q != 2'd3) dcnt_q <= ($clog2(DivW+1))'(DivW);
					dstep_q <= dstep_q + 1'b1;
				end else begin
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= DivW'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[DivW-2:0], 1'b1};
					end else begin
						rem_q <= DivW'(rem_sh);
						quo_q <= {quo_q[DivW-2:0], 1'b0};
					end
					num_q  <= num_q << 1;
					dcnt_q <= dcnt_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// fill confidence: n/wlen in Q1.16 by restoring division over 16 quotient bits
	logic [CW:0]  cr_q;
	logic [16:0]  cq_q;
	logic [4:0]   ccnt_q;
	logic [CW+1:0] cr_sh;
	assign cr_sh = {cr_q, 1'b0};
	always_ff @(posedge clk) begin
		if (cmd.fin_start) begin
			cr_q   <= (CW + 1)'(n_q);
			cq_q   <= '0;
			ccnt_q <= 5'd16;
		end else if (ccnt_q != '0) begin
			if (cr_sh >= (CW + 2)'(wlen)) begin
				cr_q <= (CW + 1)'(cr_sh - (CW + 2)'(wlen));
				cq_q <= {cq_q[15:0], 1'b1};
			end else begin
				cr_q <= (CW + 1)'(cr_sh);
				cq_q <= {cq_q[15:0], 1'b0};
			end
			ccnt_q <= ccnt_q - 1'b1;
		end
	end
	assign conf_q = (n_q >= wlen) ? 17'd65536 : cq_q;

	logic few_c;
	assign few_c = (n_q < CW'(2));

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result.luma_variance   <= few_c ? '0 : var_q;
			result.color_spread    <= few_c ? '0 : spread_q;
			result.exposure_ratio  <= few_c ? 17'd65536 : ratio_q;
			result.fill_confidence <= conf_q;
			result.limits_met      <= few_c ?
				(32'd0 <= luma_variance_limit && 17'd65536 >= exposure_ratio_floor) :
				(var_q <= luma_variance_limit && spread_q <= color_spread_limit &&
				 ratio_q >= exposure_ratio_floor);
		end
	end

	assign sts.few       = few_c;
	assign sts.walk_last = (cnt_q == n_q);
	assign sts.unit_busy = (ust_q != U_IDLE) || cmd.acc2_start || cmd.fin_start ||
		(ccnt_q != '0);
endmodule

// ===== design/wpc_controller.sv =====
// Controller: sequences the push, clear and two-pass check of the window.
`include "window_photometric_consistency_macros.svh"
module wpc_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	output logic              out_valid,
	input  logic              out_ready,
	input  wpc_pkg::sts_t     sts,
	output wpc_pkg::cmd_t     cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_ST    = 10'b0000000010,
		S_RD1   = 10'b0000000100,
		S_AC1   = 10'b0000001000,
		S_RD2   = 10'b0000010000,
		S_LAT2  = 10'b0000100000,
		S_AC2   = 10'b0001000000,
		S_FIN   = 10'b0010000000,
		S_WAIT  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;
	state_t st_q, st_d;
	logic ovalid_q;

	logic acc_txn;
	assign acc_txn = in_valid && in_ready;
	// next item is taken once the result register is free
	assign in_ready  = (st_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		case (st_q)
			S_IDLE: begin
				if (acc_txn) begin
					cmd.push  = (action == wpc_pkg::ACT_PUSH);
					cmd.clear = (action == wpc_pkg::ACT_CLEAR);
					if (action == wpc_pkg::ACT_CHECK) begin
						cmd.start_check = 1'b1;
						st_d = S_ST;
					end
				end
			end
			S_ST: st_d = sts.few ? S_FIN : S_RD1;
			S_RD1: begin
				cmd.rd_issue = 1'b1;
				st_d = S_AC1;
			end
			S_AC1: begin
				cmd.acc1 = 1'b1;
				st_d = sts.walk_last ? S_RD2 : S_RD1;
			end
			S_RD2: begin
				cmd.rd_issue = 1'b1;
				st_d = S_LAT2;
			end
			S_LAT2: begin
				cmd.acc2_start = 1'b1;
				st_d = S_AC2;
			end
			S_AC2: begin
				if (!sts.unit_busy) st_d = sts.walk_last ? S_FIN : S_RD2;
			end
			S_FIN: begin
				cmd.fin_start = 1'b1;
				st_d = S_WAIT;
			end
			S_WAIT: if (!sts.unit_busy) st_d = S_OUT;
			S_OUT: begin
				cmd.load_out = 1'b1;
				st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.load_out) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	`WPC_ASSERT_IMP(a_ready_only_idle, clk, arst_n, in_ready, st_q == S_IDLE)
	`WPC_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.load_out, out_valid)
	`WPC_ASSERT_IMP(a_no_push_busy, clk, arst_n, cmd.push || cmd.clear, st_q == S_IDLE)
	`WPC_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(st_q))
endmodule

// ===== design/window_photometric_consistency.sv =====
// Photometric consistency checker: a push transaction stores one frame's luminance,
// exposure and Lab samples in WINDOW_MAX-deep rings. A check walks the window twice
// through the ring memory port: pass one builds the luma sums, exposure min/max and Lab
// sums; pass two forms each sample's squared Lab distance one component a cycle and
// takes its square root bit-serially. Three restoring divisions then give variance,
// exposure ratio and spread; fewer than two samples skip straight to the divisions.
// The result waits in an output register; no new transaction is taken until it has
// been taken. Registers: 0 window_length, 1 luma_variance_limit, 2 color_spread_limit,
// 3 exposure_ratio_floor, at byte addresses 0, 4, 8, 12.
module window_photometric_consistency #(
	parameter int WINDOW_MAX = wpc_pkg::WindowMaxDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wpc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output wpc_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic [6:0]  wlen_q;
	logic [31:0] vlim_q;
	logic [16:0] slim_q, rfloor_q;
	wpc_pkg::cmd_t cmd;
	wpc_pkg::sts_t sts;

	assign pready = 1'b1;

	// register file write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= 7'd64;
			vlim_q   <= 32'hFFFFFFFF;
			slim_q   <= 17'h1FFFF;
			rfloor_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				wpc_pkg::REG_WLEN:   wlen_q   <= pwdata[6:0];
				wpc_pkg::REG_VLIM:   vlim_q   <= pwdata;
				wpc_pkg::REG_SLIM:   slim_q   <= pwdata[16:0];
				wpc_pkg::REG_RFLOOR: rfloor_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			wpc_pkg::REG_WLEN:   prdata = {25'd0, wlen_q};
			wpc_pkg::REG_VLIM:   prdata = vlim_q;
			wpc_pkg::REG_SLIM:   prdata = {15'd0, slim_q};
			wpc_pkg::REG_RFLOOR: prdata = {15'd0, rfloor_q};
			default:             prdata = '0;
		endcase
	end

	wpc_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (in_data.action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wpc_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.in_item              (in_data),
		.window_length        (wlen_q),
		.luma_variance_limit  (vlim_q),
		.color_spread_limit   (slim_q),
		.exposure_ratio_floor (rfloor_q),
		.result               (out_data)
	);
endmodule

// ===== sim/tb_window_photometric_consistency.sv =====
// Testbench for the photometric consistency checker: directed and random transactions.
`timescale 1ns / 1ps
module tb_window_photometric_consistency;

	localparam int RING = wpc_pkg::WindowMaxDefault;
	localparam int IDLE_LIMIT = 20000;   // watchdog limit on cycles without a transfer

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	wpc_pkg::in_item_t  in_data;
	logic        out_valid;
	logic        out_ready;
	wpc_pkg::out_item_t out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	window_photometric_consistency u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Mirror of the block's windows and registers
	bit [15:0]   luma_win [RING];
	bit [15:0]   expo_win [RING];
	bit [14:0]   light_win [RING];
	bit [15:0]   ared_win [RING];
	bit [15:0]   byel_win [RING];
	int unsigned slot_wr;
	int unsigned samples_held;
	int unsigned win_len;
	bit [31:0]   var_limit;
	bit [16:0]   spread_limit;
	bit [16:0]   ratio_floor;

	wpc_pkg::out_item_t pending_results [$];
	int          mismatches;
	int          idle_pct;
	int          stall_pct;
	int          hold_left;
	int          quiet_cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Bit-serial floor square root
	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned c;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= x) r = c;
		end
		return r;
	endfunction

	function automatic longint signed lab_comp(input int idx, input int k);
		if (k == 0) return longint'(light_win[idx]);
		if (k == 1) return longint'($signed(ared_win[idx]));
		return longint'($signed(byel_win[idx]));
	endfunction

	// Advance the mirror by one accepted transaction; queue a result on a check
	task automatic photometric_predict(input wpc_pkg::in_item_t t);
		longint unsigned n, s1, s2, emin, emax, acc, d2, vv, rr, sp, cf;
		longint signed   lsum [3];
		longint signed   dd;
		int unsigned     first, idx;
		wpc_pkg::out_item_t r;
		case (t.action)
			wpc_pkg::ACT_PUSH: begin
				luma_win[slot_wr]  = t.luma_sample;
				expo_win[slot_wr]  = t.exposure_sample;
				light_win[slot_wr] = t.lab_lightness;
				ared_win[slot_wr]  = t.lab_green_red;
				byel_win[slot_wr]  = t.lab_blue_yellow;
				slot_wr = (slot_wr + 1) % RING;
				if (samples_held < win_len) samples_held++;
			end
			wpc_pkg::ACT_CLEAR: begin
				slot_wr = 0;
				samples_held = 0;
			end
			wpc_pkg::ACT_CHECK: begin
				n = samples_held;
				first = (slot_wr + RING - samples_held) % RING;
				vv = 0; sp = 0; rr = 65536;
				if (n >= 2) begin
					s1 = 0; s2 = 0; emin = 16'hFFFF; emax = 0; acc = 0;
					lsum[0] = 0; lsum[1] = 0; lsum[2] = 0;
					idx = first;
					for (int i = 0; i < n; i++) begin
						s1 += luma_win[idx];
						s2 += longint'(luma_win[idx]) * luma_win[idx];
						if (expo_win[idx] < emin) emin = expo_win[idx];
						if (expo_win[idx] > emax) emax = expo_win[idx];
						for (int k = 0; k < 3; k++) lsum[k] += lab_comp(idx, k);
						idx = (idx + 1) % RING;
					end
					vv = (n * s2 - s1 * s1) / (n * n);
					if (vv > 64'hFFFF_FFFF) vv = 64'hFFFF_FFFF;
					if (emax != 0) rr = (emin << 16) / emax;
					idx = first;
					for (int i = 0; i < n; i++) begin
						d2 = 0;
						for (int k = 0; k < 3; k++) begin
							dd = longint'(n) * lab_comp(idx, k) - lsum[k];
							if (dd < 0) dd = -dd;
							d2 += dd * dd;
						end
						acc += int_sqrt(d2);
						idx = (idx + 1) % RING;
					end
					sp = acc / (n * n);
					if (sp > 131071) sp = 131071;
				end
				cf = (n >= win_len) ? 65536 : (n << 16) / win_len;
				r.luma_variance   = vv[31:0];
				r.color_spread    = sp[16:0];
				r.exposure_ratio  = rr[16:0];
				r.limits_met      = (vv <= var_limit && sp <= spread_limit && rr >= ratio_floor);
				r.fill_confidence = cf[16:0];
				pending_results.push_back(r);
			end
			default: ;   // unused code: no effect
		endcase
	endtask

	// One input transaction, with optional idle cycles before it; returns at a falling edge
	task automatic send_item(input wpc_pkg::in_item_t t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		photometric_predict(t);
		@(negedge clk);
	endtask

	// Register write; the caller makes sure the block is idle
	task automatic reg_write(input logic [1:0] regsel, input logic [31:0] value);
		in_valid <= 1'b0;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {regsel, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (regsel)
			wpc_pkg::REG_WLEN: begin
				win_len = value[6:0];
				if (win_len < 1) win_len = 1;
				if (win_len > RING) win_len = RING;
				if (samples_held > win_len) samples_held = win_len;
			end
			wpc_pkg::REG_VLIM:   var_limit    = value;
			wpc_pkg::REG_SLIM:   spread_limit = value[16:0];
			wpc_pkg::REG_RFLOOR: ratio_floor  = value[16:0];
			default: ;
		endcase
	endtask

	// Drain every outstanding result, then let a trailing push settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic wpc_pkg::in_item_t make_item(input logic [1:0] act,
			input logic [15:0] lu, input logic [15:0] ex, input logic [14:0] li,
			input logic [15:0] ga, input logic [15:0] gb);
		wpc_pkg::in_item_t t;
		t.action = act; t.luma_sample = lu; t.exposure_sample = ex;
		t.lab_lightness = li; t.lab_green_red = ga; t.lab_blue_yellow = gb;
		return t;
	endfunction

	function automatic wpc_pkg::in_item_t rand_item(input logic [1:0] act);
		logic [14:0] li;
		li = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(25600));
		return make_item(act, 16'($urandom), 16'($urandom), li, 16'($urandom),
			16'($urandom));
	endfunction

	// Receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Result checker and watchdog
	always @(posedge clk) begin
		wpc_pkg::out_item_t e;
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_data);
			end else begin
				e = pending_results.pop_front();
				if (out_data.luma_variance !== e.luma_variance ||
						out_data.color_spread !== e.color_spread ||
						out_data.exposure_ratio !== e.exposure_ratio ||
						out_data.limits_met !== e.limits_met ||
						out_data.fill_confidence !== e.fill_confidence) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", e, out_data);
				end
			end
		end
	end

	// Edge cases: empty and single-sample windows, zero exposure, field extremes,
	// the unused code, and a window cut short by a register write
	task automatic test_directed();
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		send_item(make_item(wpc_pkg::ACT_PUSH, 16'hFFFF, 0, 0, 0, 0));
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		send_item(make_item(wpc_pkg::ACT_PUSH, 0, 0, 15'd25600, 16'h8000, 16'h7FFF));
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		send_item(make_item(wpc_pkg::ACT_PUSH, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'h7FFF,
			16'h8000));
		send_item(make_item(wpc_pkg::ACT_PUSH, 16'h0000, 16'h0001, 15'h0000, 16'h8000,
			16'h7FFF));
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		send_item(make_item(2'd3, 16'h1234, 16'h5678, 15'h0ABC, 16'h0DEF, 16'h0123));
		send_item(make_item(wpc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		for (int i = 0; i < 70; i++) send_item(rand_item(wpc_pkg::ACT_PUSH));
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		wait_quiet();
		reg_write(wpc_pkg::REG_WLEN, 32'd4);
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		wait_quiet();
	endtask

	// Every register at its extremes, including out-of-range window lengths
	task automatic test_registers();
		reg_write(wpc_pkg::REG_WLEN, 32'd0);
		reg_write(wpc_pkg::REG_VLIM, 32'd0);
		reg_write(wpc_pkg::REG_SLIM, 32'd0);
		reg_write(wpc_pkg::REG_RFLOOR, 32'd65536);
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		send_item(rand_item(wpc_pkg::ACT_PUSH));
		send_item(rand_item(wpc_pkg::ACT_PUSH));
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		wait_quiet();
		reg_write(wpc_pkg::REG_WLEN, 32'd127);
		reg_write(wpc_pkg::REG_VLIM, 32'hFFFF_FFFF);
		reg_write(wpc_pkg::REG_SLIM, 32'd131071);
		reg_write(wpc_pkg::REG_RFLOOR, 32'd131071);
		for (int i = 0; i < 3; i++)
			send_item(make_item(wpc_pkg::ACT_PUSH, 16'd100, 16'd7, 15'd50, 0, 0));
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		wait_quiet();
		reg_write(wpc_pkg::REG_RFLOOR, 32'd0);
		send_item(make_item(wpc_pkg::ACT_CHECK, 0, 0, 0, 0, 0));
		wait_quiet();
	endtask

	// Random window content under one idling setting; short windows mostly
	task automatic test_random(input int items, input int idle, input int stall);
		int r;
		idle_pct = idle;
		stall_pct = stall;
		for (int blk = 0; blk < items / 75; blk++) begin
			wait_quiet();
			reg_write(wpc_pkg::REG_WLEN, ($urandom_range(7) == 0) ? 32'd64
				: 32'($urandom_range(1, 16)));
			reg_write(wpc_pkg::REG_VLIM, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
				: 32'($urandom_range(32'h0200_0000)));
			reg_write(wpc_pkg::REG_SLIM, 32'($urandom_range(131071)));
			reg_write(wpc_pkg::REG_RFLOOR, 32'($urandom_range(65536)));
			for (int i = 0; i < 75; i++) begin
				r = $urandom_range(99);
				if (r < 85)      send_item(rand_item(wpc_pkg::ACT_PUSH));
				else if (r < 95) send_item(rand_item(wpc_pkg::ACT_CHECK));
				else if (r < 98) send_item(rand_item(wpc_pkg::ACT_CLEAR));
				else             send_item(rand_item(2'd3));
			end
		end
		wait_quiet();
	endtask

	// Receiver holds off while checks keep coming: the output fills and input stalls
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		reg_write(wpc_pkg::REG_WLEN, 32'd3);
		hold_left = 4000;
		for (int i = 0; i < 8; i++) begin
			send_item(rand_item(wpc_pkg::ACT_PUSH));
			send_item(rand_item(wpc_pkg::ACT_CHECK));
		end
		wait_quiet();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		slot_wr = 0;
		samples_held = 0;
		win_len = 64;
		var_limit = 32'hFFFF_FFFF;
		spread_limit = 17'd131071;
		ratio_floor = 17'd0;
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_registers();
		test_random(450, 0, 0);
		test_random(450, 61, 0);
		test_random(450, 0, 61);
		test_random(450, 31, 31);
		test_backpressure();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+design
design/wpc_pkg.sv
design/wpc_datapath.sv
design/wpc_controller.sv
design/window_photometric_consistency.sv
sim/tb_window_photometric_consistency.sv
